// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cram_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C register access master package
// Beat types, transaction state, phase codes and register indexes.
// ---------------------------------------------------------------------------
package i2cram_pkg;

	// Request actions.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_SLAVE_ADDRESS = 1'b0;
	localparam logic CFG_ACK_LIMIT     = 1'b1;

	// Configuration reset values.
	localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd30;
	localparam logic [7:0] ACK_LIMIT_RESET     = 8'd250;

	// Transaction stages (upper three bits of the phase).
	localparam logic [2:0] STG_IDLE   = 3'd0;
	localparam logic [2:0] STG_ADDR_W = 3'd1;
	localparam logic [2:0] STG_REG    = 3'd2;
	localparam logic [2:0] STG_DATA   = 3'd3;
	localparam logic [2:0] STG_ADDR_R = 3'd4;
	localparam logic [2:0] STG_RECV   = 3'd5;
	localparam logic [2:0] STG_STOP   = 3'd6;

	// Sub-steps within a transmit stage.
	localparam logic [2:0] SUB_START_HI   = 3'd0;
	localparam logic [2:0] SUB_START_FALL = 3'd1;
	localparam logic [2:0] SUB_BIT_LOW    = 3'd2;
	localparam logic [2:0] SUB_BIT_HIGH   = 3'd3;
	localparam logic [2:0] SUB_ACK_LOW    = 3'd4;
	localparam logic [2:0] SUB_ACK_HIGH   = 3'd5;
	localparam logic [2:0] SUB_RESTART    = 3'd6;

	// Sub-steps of the receive stage.
	localparam logic [2:0] SUB_NACK_LOW  = 3'd4;
	localparam logic [2:0] SUB_NACK_HIGH = 3'd5;

	// Sub-steps of the stop stage.
	localparam logic [2:0] SUB_STOP_LOW  = 3'd0;
	localparam logic [2:0] SUB_STOP_HOLD = 3'd1;
	localparam logic [2:0] SUB_STOP_RISE = 3'd2;

	localparam logic [5:0] PH_IDLE = {STG_IDLE, SUB_START_HI};

	// One request beat: a half-bit tick of the bus.
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	// One result beat: bus levels and status for that tick.
	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} res_t;

	// Transaction state carried from tick to tick.
	typedef struct packed {
		logic [5:0] phase;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [7:0] received_byte;
		logic [7:0] ack_wait;
		logic       is_read;
		logic [7:0] held_data;
		logic [7:0] held_reg;
	} xfer_state_t;

	localparam xfer_state_t XFER_STATE_RESET = '{
		phase:         PH_IDLE,
		bit_count:     4'd0,
		shift_byte:    8'd0,
		received_byte: 8'd0,
		ack_wait:      8'd0,
		is_read:       1'b0,
		held_data:     8'd0,
		held_reg:      8'd0
	};

endpackage

// ===== rtl/core/i2cram_step.sv =====
// ---------------------------------------------------------------------------
// I2C register access master tick logic
// Works out the bus levels and the next transaction state for one tick.
// ---------------------------------------------------------------------------
module i2cram_step
	import i2cram_pkg::*;
(
	input  xfer_state_t cur,
	input  req_t        item,
	input  logic [6:0]  slave_address,
	input  logic [7:0]  ack_limit,
	output xfer_state_t nxt,
	output res_t        res
);

	// Byte loaded into the shifter at the start of each transmit stage.
	function automatic logic [7:0] stage_byte(input logic [2:0] stg,
	                                          input xfer_state_t s,
	                                          input logic [6:0] addr);
		logic [7:0] b;
		begin
			case (stg)
				STG_ADDR_W: b = {addr, 1'b0};
				STG_REG:    b = s.held_reg;
				STG_DATA:   b = s.held_data;
				STG_ADDR_R: b = {addr, 1'b1};
				default:    b = 8'd0;
			endcase
			return b;
		end
	endfunction

	xfer_state_t st;
	logic [2:0]  stage;
	logic [2:0]  sub;
	logic [3:0]  bc_inc;
	logic        tx_stage;
	logic        scl;
	logic        drv;
	logic        lvl;
	logic        busy;
	logic        done;

	always_comb begin
		// A request is captured only when the master is idle.
		st = cur;
		if (cur.phase == PH_IDLE && (item.action == ACT_WRITE || item.action == ACT_READ)) begin
			st.held_reg  = item.reg_addr;
			st.held_data = item.write_data;
			st.is_read   = (item.action == ACT_READ);
			st.phase     = {STG_ADDR_W, SUB_START_HI};
		end

		stage    = st.phase[5:3];
		sub      = st.phase[2:0];
		bc_inc   = st.bit_count + 4'd1;
		tx_stage = (stage >= STG_ADDR_W) && (stage <= STG_ADDR_R);

		nxt  = st;
		scl  = 1'b1;
		drv  = 1'b1;
		lvl  = 1'b1;
		busy = 1'b1;
		done = 1'b0;

		if (stage == STG_ADDR_R && sub == SUB_RESTART) begin
			// Repeated START set-up: SCL low with SDA high.
			scl       = 1'b0;
			nxt.phase = {STG_ADDR_R, SUB_START_HI};
		end else if ((stage == STG_ADDR_W || stage == STG_ADDR_R) && sub == SUB_START_HI) begin
			nxt.phase = {stage, SUB_START_FALL};
		end else if ((stage == STG_ADDR_W || stage == STG_ADDR_R) && sub == SUB_START_FALL) begin
			// START: SDA falls while SCL is high.
			lvl            = 1'b0;
			nxt.phase      = {stage, SUB_BIT_LOW};
			nxt.shift_byte = stage_byte(stage, st, slave_address);
			nxt.bit_count  = 4'd0;
		end else if (tx_stage && (sub == SUB_BIT_LOW || sub == SUB_BIT_HIGH)) begin
			// Data bit, MSB first.
			lvl = st.shift_byte[7];
			if (sub == SUB_BIT_LOW) begin
				scl       = 1'b0;
				nxt.phase = {stage, SUB_BIT_HIGH};
			end else begin
				nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
				nxt.bit_count  = bc_inc;
				nxt.phase      = bc_inc[3] ? {stage, SUB_ACK_LOW} : {stage, SUB_BIT_LOW};
			end
		end else if (tx_stage && sub == SUB_ACK_LOW) begin
			scl          = 1'b0;
			drv          = 1'b0;
			lvl          = 1'b0;
			nxt.ack_wait = 8'd0;
			nxt.phase    = {stage, SUB_ACK_HIGH};
		end else if (tx_stage && sub == SUB_ACK_HIGH) begin
			// Ack slot: hold SCL high while SDA is high, up to the limit.
			drv = 1'b0;
			lvl = 1'b0;
			if (item.sda_in && st.ack_wait < ack_limit) begin
				nxt.ack_wait = st.ack_wait + 8'd1;
			end else if (stage == STG_ADDR_W) begin
				nxt.phase      = {STG_REG, SUB_BIT_LOW};
				nxt.shift_byte = stage_byte(STG_REG, st, slave_address);
				nxt.bit_count  = 4'd0;
			end else if (stage == STG_REG) begin
				if (st.is_read) begin
					nxt.phase = {STG_ADDR_R, SUB_RESTART};
				end else begin
					nxt.phase      = {STG_DATA, SUB_BIT_LOW};
					nxt.shift_byte = stage_byte(STG_DATA, st, slave_address);
					nxt.bit_count  = 4'd0;
				end
			end else if (stage == STG_DATA) begin
				nxt.phase = {STG_STOP, SUB_STOP_LOW};
			end else begin
				nxt.phase      = {STG_RECV, SUB_BIT_LOW};
				nxt.shift_byte = 8'd0;
				nxt.bit_count  = 4'd0;
			end
		end else if (stage == STG_RECV && sub == SUB_BIT_LOW) begin
			scl       = 1'b0;
			drv       = 1'b0;
			lvl       = 1'b0;
			nxt.phase = {STG_RECV, SUB_BIT_HIGH};
		end else if (stage == STG_RECV && sub == SUB_BIT_HIGH) begin
			// Sample SDA into the shifter, MSB first.
			drv            = 1'b0;
			lvl            = 1'b0;
			nxt.shift_byte = {st.shift_byte[6:0], item.sda_in};
			nxt.bit_count  = bc_inc;
			nxt.phase      = bc_inc[3] ? {STG_RECV, SUB_NACK_LOW} : {STG_RECV, SUB_BIT_LOW};
		end else if (stage == STG_RECV && sub == SUB_NACK_LOW) begin
			// Master NACK: SDA held high.
			scl       = 1'b0;
			nxt.phase = {STG_RECV, SUB_NACK_HIGH};
		end else if (stage == STG_RECV && sub == SUB_NACK_HIGH) begin
			nxt.phase = {STG_STOP, SUB_STOP_LOW};
		end else if (stage == STG_STOP && sub == SUB_STOP_LOW) begin
			scl       = 1'b0;
			lvl       = 1'b0;
			nxt.phase = {STG_STOP, SUB_STOP_HOLD};
		end else if (stage == STG_STOP && sub == SUB_STOP_HOLD) begin
			lvl       = 1'b0;
			nxt.phase = {STG_STOP, SUB_STOP_RISE};
		end else if (stage == STG_STOP && sub == SUB_STOP_RISE) begin
			// STOP: SDA rises while SCL is high.
			done = 1'b1;
			if (st.is_read) begin
				nxt.received_byte = st.shift_byte;
			end
			nxt.phase = PH_IDLE;
		end else begin
			busy      = 1'b0;
			nxt.phase = PH_IDLE;
		end

		res.scl_level = scl;
		res.sda_drive = drv;
		res.sda_level = lvl;
		res.busy_res  = busy;
		res.done_res  = done;
		res.read_data = nxt.received_byte;
	end

endmodule

// ===== rtl/core/i2c_register_access_master_unit.sv =====
// A request beat is held in the input register, its result in the result register.
// One beat per cycle while the result is not stalled; the tick logic is combinational.
// A stalled result holds the input register, which then stalls new requests.
// Reset clears the transaction state and the valid flags of both beat registers, and
// loads the register defaults.
// ---------------------------------------------------------------------------
// I2C register access master
// Half-bit tick engine for single register reads and writes over I2C.
// ---------------------------------------------------------------------------
module i2c_register_access_master_unit
	import i2cram_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res
);

	logic        valid_s1;
	req_t        item_s1;
	logic        res_valid_s2;
	res_t        res_s2;
	xfer_state_t state_q;
	xfer_state_t state_nxt;
	res_t        step_res;
	logic [6:0]  slave_address_q;
	logic [7:0]  ack_limit_q;
	logic        advance;
	logic        req_take;

	// A beat moves on when the result register is empty or being drained.
	assign advance   = valid_s1 && (!res_valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDRESS_RESET;
			ack_limit_q     <= ACK_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDRESS: slave_address_q <= cfg_data[6:0];
				CFG_ACK_LIMIT:     ack_limit_q     <= cfg_data;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1 <= req;
		end
	end

	i2cram_step u_step (
		.cur           (state_q),
		.item          (item_s1),
		.slave_address (slave_address_q),
		.ack_limit     (ack_limit_q),
		.nxt           (state_nxt),
		.res           (step_res)
	);

	// Transaction state, updated once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= XFER_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

// ===== rtl/core/i2cram_checker.sv =====
// ---------------------------------------------------------------------------
// I2C register access master checker
// Port-level assertions on the result beats of the master.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cram_checker
	import i2cram_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// A stalled result beat stays and holds its payload.
	`CHK_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result beat changed while stalled")

	// The finishing tick is a STOP: SCL high, SDA driven high, still busy.
	`CHK_IMPLY(a_done_stop, clk, arst_n, res_valid && res.done_res, res.busy_res && res.scl_level && res.sda_drive && res.sda_level, "done tick is not a STOP")

	// A released SDA line always shows level zero.
	`CHK_IMPLY(a_released_low, clk, arst_n, res_valid && !res.sda_drive, !res.sda_level, "released SDA shows level one")

	// Idle ticks leave the bus high and report no completion.
	`CHK_IMPLY(a_idle_bus, clk, arst_n, res_valid && !res.busy_res, res.scl_level && res.sda_drive && res.sda_level && !res.done_res, "idle tick does not leave the bus high")

endmodule

bind i2c_register_access_master_unit i2cram_checker u_i2cram_checker (.*);

// ===== dv/i2c_register_access_master_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C register access master testbench
// Sends half-bit tick beats through the master, with write and read requests
// mixed into them. Each accepted beat is run through a local model of the bus
// sequencer. Every result beat is checked against the oldest predicted beat.
// The run changes the slave address and the ack limit between phases and
// idles both channels at random.
// ---------------------------------------------------------------------------
module i2c_register_access_master_unit_tb;
	import i2cram_pkg::*;

	// An action value with no meaning of its own; the master treats it as a tick.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_SLAVE_ADDRESS;
	logic [7:0] cfg_data = 8'd0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_t       res;

	i2c_register_access_master_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the sequencer state and of the two registers.
	xfer_state_t bus_st = XFER_STATE_RESET;
	logic [6:0]  cfg_slave = SLAVE_ADDRESS_RESET;
	logic [7:0]  cfg_ack_limit = ACK_LIMIT_RESET;

	req_t tick_q[$];
	res_t bus_expect_q[$];
	res_t want_beat;

	int  mismatch_cnt = 0;
	int  shown_cnt = 0;
	int  gap_odds = 4;
	int  stall_odds = 4;
	int  gap_left = 0;
	int  hold_left = 0;
	bit  long_hold_req = 1'b0;
	bit  beat_taken = 1'b0;

	// Loads the byte that a transmit stage shifts out, MSB first.
	function automatic void load_byte(input logic [2:0] stg);
		case (stg)
			STG_ADDR_W: bus_st.shift_byte = {cfg_slave, 1'b0};
			STG_REG:    bus_st.shift_byte = bus_st.held_reg;
			STG_DATA:   bus_st.shift_byte = bus_st.held_data;
			STG_ADDR_R: bus_st.shift_byte = {cfg_slave, 1'b1};
			default:    bus_st.shift_byte = 8'd0;
		endcase
		bus_st.phase = {stg, SUB_BIT_LOW};
		bus_st.bit_count = 4'd0;
	endfunction

	// Advances the bus sequencer by one half-bit tick and returns the bus levels.
	function automatic res_t tick_bus(input req_t r);
		res_t       o;
		logic [2:0] stg;
		logic [2:0] sub;
		logic       xmit;
		o.scl_level = 1'b1;
		o.sda_drive = 1'b1;
		o.sda_level = 1'b1;
		o.busy_res  = 1'b1;
		o.done_res  = 1'b0;
		// A request is only taken while the bus is idle.
		if (bus_st.phase == PH_IDLE && (r.action == ACT_WRITE || r.action == ACT_READ)) begin
			bus_st.held_reg  = r.reg_addr;
			bus_st.held_data = r.write_data;
			bus_st.is_read   = (r.action == ACT_READ);
			bus_st.phase     = {STG_ADDR_W, SUB_START_HI};
		end
		stg  = bus_st.phase[5:3];
		sub  = bus_st.phase[2:0];
		xmit = (stg >= STG_ADDR_W && stg <= STG_ADDR_R);
		if (stg == STG_ADDR_R && sub == SUB_RESTART) begin
			o.scl_level = 1'b0;
			bus_st.phase = {STG_ADDR_R, SUB_START_HI};
		end else if ((stg == STG_ADDR_W || stg == STG_ADDR_R) && sub == SUB_START_HI) begin
			bus_st.phase = {stg, SUB_START_FALL};
		end else if ((stg == STG_ADDR_W || stg == STG_ADDR_R) && sub == SUB_START_FALL) begin
			o.sda_level = 1'b0;
			load_byte(stg);
		end else if (xmit && (sub == SUB_BIT_LOW || sub == SUB_BIT_HIGH)) begin
			o.sda_level = bus_st.shift_byte[7];
			if (sub == SUB_BIT_LOW) begin
				o.scl_level = 1'b0;
				bus_st.phase = {stg, SUB_BIT_HIGH};
			end else begin
				bus_st.shift_byte = bus_st.shift_byte << 1;
				bus_st.bit_count  = bus_st.bit_count + 4'd1;
				bus_st.phase = (bus_st.bit_count >= 4'd8) ? {stg, SUB_ACK_LOW} : {stg, SUB_BIT_LOW};
			end
		end else if (xmit && sub == SUB_ACK_LOW) begin
			o.scl_level = 1'b0;
			o.sda_drive = 1'b0;
			o.sda_level = 1'b0;
			bus_st.ack_wait = 8'd0;
			bus_st.phase = {stg, SUB_ACK_HIGH};
		end else if (xmit && sub == SUB_ACK_HIGH) begin
			o.sda_drive = 1'b0;
			o.sda_level = 1'b0;
			// SCL stays high while SDA reads high, up to the ack limit.
			if (r.sda_in && bus_st.ack_wait < cfg_ack_limit) begin
				bus_st.ack_wait = bus_st.ack_wait + 8'd1;
			end else begin
				case (stg)
					STG_ADDR_W: load_byte(STG_REG);
					STG_REG: begin
						if (bus_st.is_read)
							bus_st.phase = {STG_ADDR_R, SUB_RESTART};
						else
							load_byte(STG_DATA);
					end
					STG_DATA: bus_st.phase = {STG_STOP, SUB_STOP_LOW};
					default: begin
						bus_st.phase = {STG_RECV, SUB_BIT_LOW};
						bus_st.shift_byte = 8'd0;
						bus_st.bit_count = 4'd0;
					end
				endcase
			end
		end else if (stg == STG_RECV && sub == SUB_BIT_LOW) begin
			o.scl_level = 1'b0;
			o.sda_drive = 1'b0;
			o.sda_level = 1'b0;
			bus_st.phase = {STG_RECV, SUB_BIT_HIGH};
		end else if (stg == STG_RECV && sub == SUB_BIT_HIGH) begin
			o.sda_drive = 1'b0;
			o.sda_level = 1'b0;
			bus_st.shift_byte = {bus_st.shift_byte[6:0], r.sda_in};
			bus_st.bit_count  = bus_st.bit_count + 4'd1;
			bus_st.phase = (bus_st.bit_count >= 4'd8) ? {STG_RECV, SUB_NACK_LOW}
				: {STG_RECV, SUB_BIT_LOW};
		end else if (stg == STG_RECV && sub == SUB_NACK_LOW) begin
			o.scl_level = 1'b0;
			bus_st.phase = {STG_RECV, SUB_NACK_HIGH};
		end else if (stg == STG_RECV && sub == SUB_NACK_HIGH) begin
			bus_st.phase = {STG_STOP, SUB_STOP_LOW};
		end else if (stg == STG_STOP && sub == SUB_STOP_LOW) begin
			o.scl_level = 1'b0;
			o.sda_level = 1'b0;
			bus_st.phase = {STG_STOP, SUB_STOP_HOLD};
		end else if (stg == STG_STOP && sub == SUB_STOP_HOLD) begin
			o.sda_level = 1'b0;
			bus_st.phase = {STG_STOP, SUB_STOP_RISE};
		end else if (stg == STG_STOP && sub == SUB_STOP_RISE) begin
			o.done_res = 1'b1;
			if (bus_st.is_read)
				bus_st.received_byte = bus_st.shift_byte;
			bus_st.phase = PH_IDLE;
		end else begin
			o.busy_res = 1'b0;
			bus_st.phase = PH_IDLE;
		end
		o.read_data = bus_st.received_byte;
		return o;
	endfunction

	function automatic void push_req(input logic [1:0] act, input logic [7:0] ra,
		input logic [7:0] wd, input logic sda);
		req_t item;
		item.action     = act;
		item.reg_addr   = ra;
		item.write_data = wd;
		item.sda_in     = sda;
		tick_q.push_back(item);
	endfunction

	// Register writes happen only with the bus idle and nothing in flight.
	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SLAVE_ADDRESS)
			cfg_slave = val[6:0];
		else
			cfg_ack_limit = val;
	endtask

	// Waits until every beat has come back, topping up with ticks until the
	// transaction in progress has finished, then lets the pipeline settle.
	task automatic drain_bus();
		do begin
			while (tick_q.size() != 0 || req_valid || bus_expect_q.size() != 0)
				@(posedge clk);
			if (bus_st.phase != PH_IDLE)
				repeat (16) push_req(ACT_TICK, 8'($urandom), 8'($urandom), 1'b0);
		end while (bus_st.phase != PH_IDLE);
		repeat (4) @(posedge clk);
	endtask

	// Mostly whole transactions with random bus content; some loose noise beats.
	task automatic queue_sequences(input int n);
		int   pushed;
		int   span;
		int   mode;
		logic sda;
		pushed = 0;
		while (pushed < n) begin
			mode = $urandom_range(0, 4);
			if ($urandom_range(0, 4) == 0) begin
				span = $urandom_range(1, 6);
				repeat (span)
					push_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
				pushed += span;
			end else begin
				push_req($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, 8'($urandom),
					8'($urandom), 1'($urandom_range(0, 1)));
				span = $urandom_range(30, 130);
				repeat (span) begin
					case (mode)
						0:       sda = ($urandom_range(0, 7) != 0);
						1:       sda = ($urandom_range(0, 7) == 0);
						default: sda = 1'($urandom_range(0, 1));
					endcase
					push_req(($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : ACT_TICK,
						8'($urandom), 8'($urandom), sda);
				end
				pushed += span + 1;
			end
		end
	endtask

	// Request driver: a new beat is offered only once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || beat_taken) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (tick_q.size() == 0) begin
				req_valid <= 1'b0;
			end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				gap_left = $urandom_range(0, 6);
				req_valid <= 1'b0;
			end else begin
				req <= tick_q.pop_front();
				req_valid <= 1'b1;
			end
		end
	end

	// Result receiver: short random stalls, and one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 80;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			hold_left = $urandom_range(0, 6);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Prediction on each accepted request beat, checking on each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				bus_expect_q.push_back(tick_bus(req));
				beat_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				if (bus_expect_q.size() == 0) begin
					mismatch_cnt++;
					if (shown_cnt < 10) begin
						shown_cnt++;
						$display("%0t: result beat with nothing outstanding: %p", $realtime, res);
					end
				end else begin
					want_beat = bus_expect_q.pop_front();
					if (res.scl_level !== want_beat.scl_level || res.sda_drive !== want_beat.sda_drive
						|| res.sda_level !== want_beat.sda_level
						|| res.busy_res !== want_beat.busy_res
						|| res.done_res !== want_beat.done_res
						|| res.read_data !== want_beat.read_data) begin
						mismatch_cnt++;
						if (shown_cnt < 10) begin
							shown_cnt++;
							$display("%0t: result beat differs: expected %p, got %p",
								$realtime, want_beat, res);
						end
					end
				end
			end
		end
	end

	initial begin
		int p;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: plain ticks, the unused action, a write with a start request
		// arriving while busy, then a write with a read request behind it and patterned SDA.
		push_req(ACT_TICK, 8'h00, 8'h00, 1'b0);
		push_req(ACT_UNUSED, 8'hFF, 8'hFF, 1'b1);
		push_req(ACT_WRITE, 8'hFF, 8'h00, 1'b0);
		for (int i = 0; i < 64; i++)
			push_req((i == 12) ? ACT_READ : ACT_TICK, 8'h5A, 8'hA5, 1'b0);
		drain_bus();
		push_req(ACT_WRITE, 8'h00, 8'hFF, 1'b0);
		push_req(ACT_READ, 8'h00, 8'hFF, 1'b0);
		for (int i = 0; i < 120; i++)
			push_req(ACT_TICK, 8'($urandom), 8'($urandom), i[1] ^ i[3]);
		drain_bus();

		// Random phases, each with its own register settings, most with random idling.
		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin
					write_reg(CFG_SLAVE_ADDRESS, 8'h80);
					write_reg(CFG_ACK_LIMIT, 8'd0);
				end
				1: begin
					write_reg(CFG_SLAVE_ADDRESS, 8'h7F);
					write_reg(CFG_ACK_LIMIT, 8'd255);
				end
				2: begin
					write_reg(CFG_SLAVE_ADDRESS, 8'($urandom));
					write_reg(CFG_ACK_LIMIT, 8'd1);
				end
				5: begin
					write_reg(CFG_SLAVE_ADDRESS, 8'($urandom));
					write_reg(CFG_ACK_LIMIT, 8'd3);
				end
				default: begin
					write_reg(CFG_SLAVE_ADDRESS, 8'($urandom));
					write_reg(CFG_ACK_LIMIT, 8'($urandom_range(0, 15)));
				end
			endcase
			case (p)
				0:       begin gap_odds = 4;  stall_odds = 12; end
				1:       begin gap_odds = 12; stall_odds = 3;  end
				3:       begin gap_odds = 3;  stall_odds = 8;  end
				4:       begin gap_odds = 8;  stall_odds = 4;  end
				default: begin gap_odds = 0;  stall_odds = 0;  end
			endcase
			// With the longest ack limit, a read whose first ack slot runs to the limit.
			if (p == 1) begin
				push_req(ACT_READ, 8'($urandom), 8'($urandom), 1'b1);
				repeat (300) push_req(ACT_TICK, 8'($urandom), 8'($urandom), 1'b1);
			end
			queue_sequences(60);
			if (p == 3)
				long_hold_req = 1'b1;
			drain_bus();
		end

		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && bus_expect_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
